/* rtl/oep_pkg.sv */
// Shared types and constants for the orbital energy / prograde guidance block.
// No dependencies.
package oep_pkg;

   localparam int GRAV_W      = 51;
   localparam int SQRT_STAGES = 32;
   localparam int POT_STAGES  = 49;
   localparam int DIR_STAGES  = 16;
   // accept -> squares -> sums -> sqrt -> potential divide -> merge
   localparam int LATENCY     = 2 + SQRT_STAGES + POT_STAGES + 1;

   localparam logic [GRAV_W-1:0] GRAV_RESET = 51'd398600441800000;
   localparam logic [48:0]       POT_CAP    = 49'h1_0000_0000_0000;
   localparam logic [15:0]       DIR_MAX    = 16'd32767;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic signed [31:0] prop_mass;
   } req_type;

   typedef struct packed {
      logic signed [47:0] energy;
      logic               thrust_on;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
      logic               degenerate;
   } rsp_type;

   // absolute value of a 32-bit signed word, 32 bits unsigned
   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      logic [31:0] r;
      r = v[31] ? (32'd0 - v) : v;
      return r;
   endfunction

endpackage

/* rtl/oep_isqrt.sv */
// Pipelined integer square root, one result bit per stage (32 stages).
// Depends on oep_pkg.
module oep_isqrt (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] n_i,
   output logic [31:0] root_o
);

   logic [63:0] n_ff    [0:oep_pkg::SQRT_STAGES-1];
   logic [33:0] rem_ff  [0:oep_pkg::SQRT_STAGES-1];
   logic [31:0] root_ff [0:oep_pkg::SQRT_STAGES-1];

   for (genvar k = 0; k < oep_pkg::SQRT_STAGES; k++) begin : g_stage
      logic [63:0] n_prev;
      logic [33:0] rem_prev;
      logic [31:0] root_prev;
      logic [35:0] rem_sh;
      logic [35:0] trial;
      logic [33:0] rem_in;
      logic [31:0] root_in;

      if (k == 0) begin : g_first
         assign n_prev    = n_i;
         assign rem_prev  = '0;
         assign root_prev = '0;
      end else begin : g_next
         assign n_prev    = n_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
      end

      always_comb begin
         rem_sh = {rem_prev, n_prev[2*(31-k)+1 -: 2]};
         trial  = {2'b00, root_prev, 2'b01};
         if (rem_sh >= trial) begin
            rem_in  = 34'(rem_sh - trial);
            root_in = {root_prev[30:0], 1'b1};
         end else begin
            rem_in  = rem_sh[33:0];
            root_in = {root_prev[30:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            n_ff[k]    <= n_prev;
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
         end
      end
   end

   assign root_o = root_ff[oep_pkg::SQRT_STAGES-1];

endmodule

/* rtl/oep_pot_div.sv */
// Pipelined potential term: min(floor(mu * 2^16 / R), 2^48), one bit per stage.
// Depends on oep_pkg.
module oep_pot_div (
   input  logic                       clock,
   input  logic                       en,
   input  logic [oep_pkg::GRAV_W-1:0] mu_i,
   input  logic [31:0]                radius_i,
   output logic [48:0]                pot_o
);

   logic [31:0] r_ff   [0:oep_pkg::POT_STAGES-1];
   logic [31:0] rem_ff [0:oep_pkg::POT_STAGES-1];
   logic [48:0] q_ff   [0:oep_pkg::POT_STAGES-1];
   logic        cap_ff [0:oep_pkg::POT_STAGES-1];

   for (genvar k = 0; k < oep_pkg::POT_STAGES; k++) begin : g_stage
      localparam int B = oep_pkg::POT_STAGES - 1 - k;
      logic [31:0] r_prev;
      logic [31:0] rem_prev;
      logic [48:0] q_prev;
      logic        cap_prev;
      logic        dbit;
      logic [32:0] rem_sh;
      logic        ge;

      if (k == 0) begin : g_first
         // quotient of 2^49 or more, or zero radius, pins the cap
         assign r_prev   = radius_i;
         assign rem_prev = {14'd0, mu_i[50:33]};
         assign q_prev   = '0;
         assign cap_prev = (radius_i == 32'd0) || ({14'd0, mu_i[50:33]} >= radius_i);
      end else begin : g_next
         assign r_prev   = r_ff[k-1];
         assign rem_prev = rem_ff[k-1];
         assign q_prev   = q_ff[k-1];
         assign cap_prev = cap_ff[k-1];
      end

      if (B >= 16) begin : g_bit
         assign dbit = mu_i[B-16];
      end else begin : g_zero
         assign dbit = 1'b0;
      end

      assign rem_sh = {rem_prev, dbit};
      assign ge     = rem_sh >= {1'b0, r_prev};

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[k]   <= r_prev;
            rem_ff[k] <= ge ? 32'(rem_sh - {1'b0, r_prev}) : rem_sh[31:0];
            q_ff[k]   <= {q_prev[47:0], ge};
            cap_ff[k] <= cap_prev;
         end
      end
   end

   always_comb begin
      if (cap_ff[oep_pkg::POT_STAGES-1] ||
          (q_ff[oep_pkg::POT_STAGES-1] > oep_pkg::POT_CAP)) begin
         pot_o = oep_pkg::POT_CAP;
      end else begin
         pot_o = q_ff[oep_pkg::POT_STAGES-1];
      end
   end

endmodule

/* rtl/oep_dir_lane.sv */
// One direction lane: min(floor(|v_i| * 2^15 / W), 32767), one bit per stage.
// Depends on oep_pkg.
module oep_dir_lane (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] mag_i,
   input  logic [31:0] speed_i,
   output logic [15:0] dir_o
);

   logic [31:0] w_ff   [0:oep_pkg::DIR_STAGES-1];
   logic [31:0] rem_ff [0:oep_pkg::DIR_STAGES-1];
   logic [15:0] q_ff   [0:oep_pkg::DIR_STAGES-1];

   for (genvar k = 0; k < oep_pkg::DIR_STAGES; k++) begin : g_stage
      logic [31:0] w_prev;
      logic [31:0] rem_prev;
      logic [15:0] q_prev;
      logic        dbit;
      logic [32:0] rem_sh;
      logic        ge;

      if (k == 0) begin : g_first
         // |v_i| <= W, so the top part is already below the divisor
         assign w_prev   = speed_i;
         assign rem_prev = {1'b0, mag_i[31:1]};
         assign q_prev   = '0;
         assign dbit     = mag_i[0];
      end else begin : g_next
         assign w_prev   = w_ff[k-1];
         assign rem_prev = rem_ff[k-1];
         assign q_prev   = q_ff[k-1];
         assign dbit     = 1'b0;
      end

      assign rem_sh = {rem_prev, dbit};
      assign ge     = rem_sh >= {1'b0, w_prev};

      always_ff @(posedge clock) begin
         if (en) begin
            w_ff[k]   <= w_prev;
            rem_ff[k] <= ge ? 32'(rem_sh - {1'b0, w_prev}) : rem_sh[31:0];
            q_ff[k]   <= {q_prev[14:0], ge};
         end
      end
   end

   assign dir_o = q_ff[oep_pkg::DIR_STAGES-1][15] ? oep_pkg::DIR_MAX
                                                  : q_ff[oep_pkg::DIR_STAGES-1];

endmodule

/* rtl/orbital_energy_prograde_guidance.sv */
// Top level: specific orbital energy and prograde thrust direction.
// Depends on oep_pkg, oep_isqrt, oep_pot_div, oep_dir_lane.

// Fully pipelined: one state vector is taken every cycle unless the pipe is
// stalled, and results leave in order. The first register stage loads on the
// item's accepting edge and the last is the result register that drives rsp.
// The latency is set by the 32-stage square roots followed by the 49-stage
// potential divider; the three direction lanes (16 stages each) run beside the
// divider. The whole pipe advances together and holds when the result register
// is full and not taken, so req_ready equals rsp_ready while it is full. The
// gravitational parameter grav_ff is read by the divider while an item is in
// flight and must only be written while the block is empty.
module orbital_energy_prograde_guidance (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  oep_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output oep_pkg::rsp_type           rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [oep_pkg::GRAV_W-1:0] csr_data
);

   localparam int SIDE_D = oep_pkg::SQRT_STAGES;                      // s2 -> s34
   localparam int DIR_D  = oep_pkg::POT_STAGES - oep_pkg::DIR_STAGES; // lane align
   localparam int LAST   = oep_pkg::LATENCY;

   // per-item sideband carried past the square roots
   typedef struct packed {
      logic [2:0]  neg;
      logic [31:0] mag_x;
      logic [31:0] mag_y;
      logic [31:0] mag_z;
      logic [46:0] kin;
      logic        prop_pos;
      logic        degen;
   } side_type;

   // sideband carried past the divider
   typedef struct packed {
      logic [2:0]  neg;
      logic [46:0] kin;
      logic        prop_pos;
      logic        degen;
   } tail_type;

   logic                       en;
   logic [LAST:1]              vld_ff;
   logic [oep_pkg::GRAV_W-1:0] grav_ff;

   // config register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         grav_ff <= oep_pkg::GRAV_RESET;
      end else if (csr_valid) begin
         grav_ff <= csr_data;
      end
   end

   // global pipe enable: move unless the result register is full and stalled
   assign en        = !vld_ff[LAST] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[LAST];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAST-1:1], req_valid};
      end
   end

   // s1: magnitudes and squares (a full-scale negative squares to 2^62)
   logic [31:0] pm_in [0:2];
   logic [31:0] vm_in [0:2];
   logic [62:0] psq_ff [0:2];
   logic [62:0] vsq_ff [0:2];
   side_type    s1_ff;

   assign pm_in[0] = oep_pkg::mag32(req_data.pos_x);
   assign pm_in[1] = oep_pkg::mag32(req_data.pos_y);
   assign pm_in[2] = oep_pkg::mag32(req_data.pos_z);
   assign vm_in[0] = oep_pkg::mag32(req_data.vel_x);
   assign vm_in[1] = oep_pkg::mag32(req_data.vel_y);
   assign vm_in[2] = oep_pkg::mag32(req_data.vel_z);

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            psq_ff[i] <= 63'(64'(pm_in[i]) * 64'(pm_in[i]));
            vsq_ff[i] <= 63'(64'(vm_in[i]) * 64'(vm_in[i]));
         end
         s1_ff.neg      <= {req_data.vel_z[31], req_data.vel_y[31], req_data.vel_x[31]};
         s1_ff.mag_x    <= vm_in[0];
         s1_ff.mag_y    <= vm_in[1];
         s1_ff.mag_z    <= vm_in[2];
         s1_ff.kin      <= '0;
         s1_ff.prop_pos <= !req_data.prop_mass[31] && (req_data.prop_mass != 32'sd0);
         s1_ff.degen    <= 1'b0;
      end
   end

   // s2: sums of squares; kinetic term and zero-speed flag
   logic [63:0] rsq_ff;
   logic [63:0] vsum_ff;
   logic [63:0] vsum_in;
   side_type    s2_in;
   side_type    s2_ff;

   assign vsum_in = 64'(vsq_ff[0]) + 64'(vsq_ff[1]) + 64'(vsq_ff[2]);

   always_comb begin
      s2_in       = s1_ff;
      s2_in.kin   = vsum_in[63:17];
      s2_in.degen = (vsum_in == 64'd0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsq_ff  <= 64'(psq_ff[0]) + 64'(psq_ff[1]) + 64'(psq_ff[2]);
         vsum_ff <= vsum_in;
         s2_ff   <= s2_in;
      end
   end

   // s3..s34: radius and speed
   logic [31:0] radius;
   logic [31:0] speed;

   oep_isqrt u_rad_sqrt (.clock(clock), .en(en), .n_i(rsq_ff),  .root_o(radius));
   oep_isqrt u_spd_sqrt (.clock(clock), .en(en), .n_i(vsum_ff), .root_o(speed));

   side_type side_ff [0:SIDE_D-1];
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= s2_ff;
         for (int i = 1; i < SIDE_D; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   side_type s34;
   assign s34 = side_ff[SIDE_D-1];

   // s35..s83: potential term, with the three direction lanes alongside
   logic [48:0] pot;
   oep_pot_div u_pot (
      .clock(clock), .en(en), .mu_i(grav_ff), .radius_i(radius), .pot_o(pot)
   );

   logic [15:0] lane_dir [0:2];
   oep_dir_lane u_lane_x (.clock(clock), .en(en), .mag_i(s34.mag_x), .speed_i(speed),
                          .dir_o(lane_dir[0]));
   oep_dir_lane u_lane_y (.clock(clock), .en(en), .mag_i(s34.mag_y), .speed_i(speed),
                          .dir_o(lane_dir[1]));
   oep_dir_lane u_lane_z (.clock(clock), .en(en), .mag_i(s34.mag_z), .speed_i(speed),
                          .dir_o(lane_dir[2]));

   logic [47:0] dir_dly_ff [0:DIR_D-1];
   tail_type    tail_ff    [0:oep_pkg::POT_STAGES-1];
   always_ff @(posedge clock) begin
      if (en) begin
         dir_dly_ff[0] <= {lane_dir[2], lane_dir[1], lane_dir[0]};
         for (int i = 1; i < DIR_D; i++) begin
            dir_dly_ff[i] <= dir_dly_ff[i-1];
         end
         tail_ff[0] <= '{neg: s34.neg, kin: s34.kin, prop_pos: s34.prop_pos,
                         degen: s34.degen};
         for (int i = 1; i < oep_pkg::POT_STAGES; i++) begin
            tail_ff[i] <= tail_ff[i-1];
         end
      end
   end

   // s84: merge into the result register
   tail_type           tl;
   logic [47:0]        dq;
   logic signed [49:0] diff;
   logic signed [47:0] energy_in;
   logic               thrust_in;
   logic               steer;
   logic [15:0]        dmag [0:2];
   logic [15:0]        dsel [0:2];
   oep_pkg::rsp_type   rsp_ff;

   assign tl = tail_ff[oep_pkg::POT_STAGES-1];
   assign dq = dir_dly_ff[DIR_D-1];
   assign dmag[0] = dq[15:0];
   assign dmag[1] = dq[31:16];
   assign dmag[2] = dq[47:32];

   always_comb begin
      diff = $signed({3'b000, tl.kin}) - $signed({1'b0, pot});
      if (diff > 50'sh0_7FFF_FFFF_FFFF) begin
         energy_in = 48'sh7FFF_FFFF_FFFF;
      end else if (diff < -50'sh0_8000_0000_0000) begin
         energy_in = 48'sh8000_0000_0000;
      end else begin
         energy_in = diff[47:0];
      end
      thrust_in = tl.prop_pos && energy_in[47];
      steer     = thrust_in && !tl.degen;
      for (int i = 0; i < 3; i++) begin
         if (!steer) begin
            dsel[i] = '0;
         end else if (tl.neg[i]) begin
            dsel[i] = 16'd0 - dmag[i];
         end else begin
            dsel[i] = dmag[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff.energy     <= energy_in;
         rsp_ff.thrust_on  <= thrust_in;
         rsp_ff.dir_x      <= dsel[0];
         rsp_ff.dir_y      <= dsel[1];
         rsp_ff.dir_z      <= dsel[2];
         rsp_ff.degenerate <= tl.degen;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

/* tb/sv/tb_orbital_energy_prograde_guidance.sv */
// Testbench for orbital_energy_prograde_guidance: random and directed state vectors,
// results checked in order against an internal energy / direction predictor.
// Depends on oep_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_orbital_energy_prograde_guidance;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   oep_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   oep_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [oep_pkg::GRAV_W-1:0] csr_data = '0;

   orbital_energy_prograde_guidance dut (.*);

   always #5 clock = ~clock;

   // predictor state and expected result store
   logic [oep_pkg::GRAV_W-1:0] mu_cur = oep_pkg::GRAV_RESET;
   oep_pkg::rsp_type energy_q[$];
   int errors = 0;
   int cycles = 0;
   int stall_left = 0;
   bit idle_on = 1'b1;
   bit done = 1'b0;

   localparam int CYCLE_LIMIT = 2000000;

   function automatic logic [63:0] isqrt(input logic [63:0] n);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n = n - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic logic [31:0] absval(input logic signed [31:0] v);
      return v[31] ? 32'd0 - v : v;
   endfunction

   function automatic oep_pkg::rsp_type predict_state(input oep_pkg::req_type s);
      oep_pkg::rsp_type o;
      logic [63:0] rsq, vsq, rad, spd, kin, pot, q, r, m;
      logic [31:0] pm[3], vm[3];
      logic signed [31:0] vv[3];
      logic signed [65:0] e;
      vv[0] = s.vel_x; vv[1] = s.vel_y; vv[2] = s.vel_z;
      pm[0] = absval(s.pos_x); pm[1] = absval(s.pos_y); pm[2] = absval(s.pos_z);
      rsq = 0; vsq = 0;
      for (int k = 0; k < 3; k++) begin
         vm[k] = absval(vv[k]);
         rsq = rsq + 64'(pm[k]) * 64'(pm[k]);
         vsq = vsq + 64'(vm[k]) * 64'(vm[k]);
      end
      kin = vsq >> 17;
      rad = isqrt(rsq);
      if (rad == 0) begin
         pot = 64'd1 << 48;
      end else begin
         q = 64'(mu_cur) / rad;
         r = 64'(mu_cur) % rad;
         if (q >= (64'd1 << 32)) pot = 64'd1 << 48;
         else begin
            pot = (q << 16) + ((r << 16) / rad);
            if (pot > (64'd1 << 48)) pot = 64'd1 << 48;
         end
      end
      e = $signed({2'b0, kin}) - $signed({2'b0, pot});
      if (e > 66'sh7FFF_FFFF_FFFF) e = 66'sh7FFF_FFFF_FFFF;
      if (e < -66'sh8000_0000_0000) e = -66'sh8000_0000_0000;
      o = '0;
      o.energy = e[47:0];
      o.thrust_on = (s.prop_mass > 0) && e[65];
      o.degenerate = (vsq == 0);
      if (o.thrust_on && !o.degenerate) begin
         spd = isqrt(vsq);
         for (int k = 0; k < 3; k++) begin
            m = (64'(vm[k]) << 15) / spd;
            if (m > 64'(oep_pkg::DIR_MAX)) m = 64'(oep_pkg::DIR_MAX);
            if (vv[k] < 0) m = 64'd0 - m;
            case (k)
               0: o.dir_x = m[15:0];
               1: o.dir_y = m[15:0];
               default: o.dir_z = m[15:0];
            endcase
         end
      end
      return o;
   endfunction

   // valid stays up between back-to-back items; it drops only for an idle burst
   task automatic send_state(input oep_pkg::req_type s);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= s;
      do @(posedge clock); while (!req_ready);
      energy_q.push_back(predict_state(s));
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (energy_q.size() != 0) @(negedge clock);
      repeat (oep_pkg::LATENCY + 10) @(negedge clock);
   endtask

   // only called with the pipe empty
   task automatic write_mu(input logic [oep_pkg::GRAV_W-1:0] v);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      mu_cur = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] rnd_word();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'(int'($urandom_range(0, 200)) - 100);
         default: return $urandom;
      endcase
   endfunction

   // mostly a realistic orbit-ish state with random content, else random extreme words
   function automatic oep_pkg::req_type rnd_state();
      oep_pkg::req_type s;
      if ($urandom_range(0, 3) != 0) begin
         s.pos_x = $signed($urandom_range(0, 16000000)) - 8000000;
         s.pos_y = $signed($urandom_range(0, 16000000)) - 8000000;
         s.pos_z = $signed($urandom_range(0, 16000000)) - 8000000;
         s.vel_x = ($signed($urandom_range(0, 20000)) - 10000) <<< 16 | $urandom_range(0, 65535);
         s.vel_y = ($signed($urandom_range(0, 20000)) - 10000) <<< 16 | $urandom_range(0, 65535);
         s.vel_z = ($signed($urandom_range(0, 20000)) - 10000) <<< 16 | $urandom_range(0, 65535);
         s.prop_mass = $urandom_range(0, 7) == 0 ? -$signed($urandom_range(0, 1000))
                                                 : $urandom;
      end else begin
         s.pos_x = rnd_word(); s.pos_y = rnd_word(); s.pos_z = rnd_word();
         s.vel_x = rnd_word(); s.vel_y = rnd_word(); s.vel_z = rnd_word();
         s.prop_mass = rnd_word();
      end
      return s;
   endfunction

   function automatic oep_pkg::req_type mk(input logic [31:0] px, py, pz, vx, vy, vz, pr);
      oep_pkg::req_type s;
      s.pos_x = px; s.pos_y = py; s.pos_z = pz;
      s.vel_x = vx; s.vel_y = vy; s.vel_z = vz; s.prop_mass = pr;
      return s;
   endfunction

   // result sink: random rsp_ready stall bursts while idle_on is set, in-order compare
   always @(negedge clock) begin
      if (!reset) begin
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 10);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      oep_pkg::rsp_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (energy_q.size() == 0) begin
            $error("result item with nothing expected");
            errors++;
         end else begin
            exp_r = energy_q.pop_front();
            if (rsp_data.energy !== exp_r.energy) begin
               $error("energy exp %0d got %0d", exp_r.energy, rsp_data.energy); errors++;
            end
            if (rsp_data.thrust_on !== exp_r.thrust_on) begin
               $error("thrust_on exp %0d got %0d", exp_r.thrust_on, rsp_data.thrust_on);
               errors++;
            end
            if (rsp_data.dir_x !== exp_r.dir_x) begin
               $error("dir_x exp %0d got %0d", exp_r.dir_x, rsp_data.dir_x); errors++;
            end
            if (rsp_data.dir_y !== exp_r.dir_y) begin
               $error("dir_y exp %0d got %0d", exp_r.dir_y, rsp_data.dir_y); errors++;
            end
            if (rsp_data.dir_z !== exp_r.dir_z) begin
               $error("dir_z exp %0d got %0d", exp_r.dir_z, rsp_data.dir_z); errors++;
            end
            if (rsp_data.degenerate !== exp_r.degenerate) begin
               $error("degenerate exp %0d got %0d", exp_r.degenerate, rsp_data.degenerate);
               errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT && !done) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic test_directed();
      // extremes, zero radius, zero speed, thrust off, full-scale direction
      send_state(mk(0, 0, 0, 0, 0, 0, 1));
      send_state(mk(0, 0, 0, 32'h0001_0000, 0, 0, 1));
      send_state(mk(6771000, 0, 0, 0, 0, 0, 32'h0001_0000));
      send_state(mk(6771000, 0, 0, 0, 32'h1DF0_0000, 0, 32'h0001_0000));
      send_state(mk(6771000, 0, 0, 0, 32'h1DF0_0000, 0, 0));
      send_state(mk(6771000, 0, 0, 32'h8000_0000, 0, 0, 5));
      send_state(mk(6771000, 0, 0, 32'h7FFF_FFFF, 0, 0, 5));
      send_state(mk(6771000, 0, 0, 0, 0, 32'hFFFF_FFFF, 5));
      send_state(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
      send_state(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      send_state(mk(1, 0, 0, 32'h0000_0001, 32'hFFFF_FFFF, 1, 32'h7FFF_FFFF));
      send_state(mk(0, 1, 0, 32'h0100_0000, 32'hFF00_0000, 32'h0100_0000, 1));
      send_state(mk(0, 0, 32'hFFFF_FFFF, 0, 32'h0000_8000, 0, 32'hFFFF_FFFF));
      drain();
   endtask

   task automatic test_random(input int n);
      repeat (n) send_state(rnd_state());
   endtask

   task automatic test_mu_settings();
      write_mu('0);
      test_random(150);
      drain();
      write_mu({oep_pkg::GRAV_W{1'b1}});
      test_random(150);
      drain();
      write_mu(51'h4_0000_0000_0000);
      test_random(150);
      drain();
      write_mu(oep_pkg::GRAV_W'({$urandom, $urandom}));
      test_random(150);
      drain();
      write_mu(oep_pkg::GRAV_RESET);
   endtask

   task automatic test_back_to_back();
      idle_on = 1'b0;
      test_random(400);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(600);
      drain();                  // sender holds off until every result is in
      test_mu_settings();
      test_random(400);
      test_back_to_back();
      drain();
      done = 1'b1;
      if (errors == 0 && energy_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/oep_pkg.sv
rtl/oep_isqrt.sv
rtl/oep_pot_div.sv
rtl/oep_dir_lane.sv
rtl/orbital_energy_prograde_guidance.sv
tb/sv/tb_orbital_energy_prograde_guidance.sv
